[sv/wrmll_pkg.sv]
// Package: shared widths, register indexes and control types for the log-likelihood block.
`default_nettype none
package wrmll_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned SUM_W     = 64;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODEL_KIND      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_POSITION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEF     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUBE_COEF       = 3'd4;

	typedef struct packed {
		logic step;
		logic last;
		logic ovf_set;
	} acc_ctrl_t;

endpackage
`default_nettype wire

[sv/wrmll_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module wrmll_mul
	import wrmll_pkg::*;
(
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [DATA_W:0]         a,
	input  wire logic signed [DATA_W:0]         b,
	output logic signed [2*DATA_W+1:0]          p
);

	logic signed [2*DATA_W+1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

[sv/wrmll_acc.sv]
// Running sum with saturation at its minimum, overflow flag and output register.
`default_nettype none
module wrmll_acc
	import wrmll_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire acc_ctrl_t         ctrl,
	input  wire logic [SUM_W-1:0]  term,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [SUM_W-1:0]       log_likelihood,
	output logic                   saturated
);

	logic [SUM_W-1:0] sum_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] ll_q;
	logic             sat_q;
	logic [SUM_W:0]   diff;
	logic             sum_sat;
	logic [SUM_W-1:0] sum_next;

	assign diff     = {sum_q[SUM_W-1], sum_q} - {1'b0, term};
	assign sum_sat  = diff[SUM_W] != diff[SUM_W-1];
	assign sum_next = sum_sat ? {1'b1, {(SUM_W-1){1'b0}}} : diff[SUM_W-1:0];
	assign room     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.step && ctrl.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.step) begin
				if (ctrl.last) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_next;
					ovf_q <= ovf_q | sum_sat;
				end
			end else if (ctrl.ovf_set) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && ctrl.last) begin
			ll_q  <= sum_next;
			sat_q <= ovf_q | sum_sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign log_likelihood = ll_q;
	assign saturated      = sat_q;

endmodule
`default_nettype wire

[sv/weighted_residual_loglik.sv]
// Top level: sequencer around one shared multiplier for the weighted residual log-likelihood.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data            | in
//  in      | in_valid, in_ready, position, measured_value,        | in
//          | inverse_error, last_point                            |
//  out     | out_valid, out_ready, log_likelihood, saturated      | out
//
// A point steps through the offset, the model products, the residual, the weighting and
// the accumulate step, the cubic model adding two products; each product is registered in
// the single multiplier and then truncated and stored, but the last one goes to the sum.
// Reset clears the sequencer, the configuration registers, the running sum, the flag and the output valid.
// A last point waits in the final step while the output register still holds an
// untaken beat; the next point is accepted while a finished beat waits.
`default_nettype none
module weighted_residual_loglik
	import wrmll_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [DATA_W-1:0]    position,
	input  wire logic [DATA_W-1:0]    measured_value,
	input  wire logic [DATA_W-1:0]    inverse_error,
	input  wire logic                 last_point,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [SUM_W-1:0]          log_likelihood,
	output logic                      saturated
);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_DIFF  = 15'b000000000000010,
		ST_M_D2  = 15'b000000000000100,
		ST_T_D2  = 15'b000000000001000,
		ST_M_SQ  = 15'b000000000010000,
		ST_T_SQ  = 15'b000000000100000,
		ST_M_D3  = 15'b000000001000000,
		ST_T_D3  = 15'b000000010000000,
		ST_M_CU  = 15'b000000100000000,
		ST_T_CU  = 15'b000001000000000,
		ST_RESID = 15'b000010000000000,
		ST_M_W   = 15'b000100000000000,
		ST_T_W   = 15'b001000000000000,
		ST_M_WW  = 15'b010000000000000,
		ST_ACC   = 15'b100000000000000
	} state_t;

	localparam int unsigned PROD_W = 2 * DATA_W + 2;

	state_t state_q;
	state_t state_d;

	logic              kind_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] center_q;
	logic [DATA_W-1:0] square_q;
	logic [DATA_W-1:0] cube_q;

	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] ie_q;
	logic              last_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W+1:0] acc_q;

	logic signed [DATA_W:0]   mul_a;
	logic signed [DATA_W:0]   mul_b;
	logic                     mul_en;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] p_sh;
	logic [PROD_W-DATA_W:0]   p_hi;
	logic                     tr_ovf;
	logic [DATA_W-1:0]        tr_val;

	logic [DATA_W:0]   diff_w;
	logic              diff_ovf;
	logic [DATA_W-1:0] diff_val;
	logic [2:0]        mod_hi;
	logic              mod_ovf;
	logic [DATA_W-1:0] mod_val;
	logic [DATA_W:0]   res_w;
	logic              res_ovf;
	logic [DATA_W-1:0] res_val;

	logic             room;
	logic             ovf_set;
	acc_ctrl_t        acc_ctrl;
	logic [SUM_W-1:0] term;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= 1'b0;
			base_q   <= '0;
			center_q <= '0;
			square_q <= '0;
			cube_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODEL_KIND:      kind_q   <= cfg_data[0];
				REG_BASE_VALUE:      base_q   <= cfg_data;
				REG_CENTER_POSITION: center_q <= cfg_data;
				REG_SQUARE_COEF:     square_q <= cfg_data;
				REG_CUBE_COEF:       cube_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Truncation of the registered product back to a saturated 32-bit value.
	assign p_sh   = mul_p >>> FRAC_BITS;
	assign p_hi   = p_sh[PROD_W-1:DATA_W-1];
	assign tr_ovf = !((&p_hi) || !(|p_hi));
	assign tr_val = tr_ovf ? (p_sh[PROD_W-1] ? SAT_MIN : SAT_MAX) : p_sh[DATA_W-1:0];

	assign diff_w   = {t_q[DATA_W-1], t_q} - {center_q[DATA_W-1], center_q};
	assign diff_ovf = diff_w[DATA_W] != diff_w[DATA_W-1];
	assign diff_val = diff_ovf ? (diff_w[DATA_W] ? SAT_MIN : SAT_MAX) : diff_w[DATA_W-1:0];

	assign mod_hi  = acc_q[DATA_W+1:DATA_W-1];
	assign mod_ovf = !((&mod_hi) || !(|mod_hi));
	assign mod_val = mod_ovf ? (acc_q[DATA_W+1] ? SAT_MIN : SAT_MAX) : acc_q[DATA_W-1:0];

	assign res_w   = {val_q[DATA_W-1], val_q} - {mod_val[DATA_W-1], mod_val};
	assign res_ovf = res_w[DATA_W] != res_w[DATA_W-1];
	assign res_val = res_ovf ? (res_w[DATA_W] ? SAT_MIN : SAT_MAX) : res_w[DATA_W-1:0];

	always_comb begin
		mul_a  = $signed({x_q[DATA_W-1], x_q});
		mul_b  = $signed({x_q[DATA_W-1], x_q});
		mul_en = 1'b0;
		unique case (state_q)
			ST_M_D2: begin
				mul_en = 1'b1;
			end
			ST_M_SQ: begin
				mul_a  = $signed({y_q[DATA_W-1], y_q});
				mul_b  = $signed({square_q[DATA_W-1], square_q});
				mul_en = 1'b1;
			end
			ST_M_D3: begin
				mul_a  = $signed({y_q[DATA_W-1], y_q});
				mul_en = 1'b1;
			end
			ST_M_CU: begin
				mul_a  = $signed({y_q[DATA_W-1], y_q});
				mul_b  = $signed({cube_q[DATA_W-1], cube_q});
				mul_en = 1'b1;
			end
			ST_M_W: begin
				mul_b  = $signed({1'b0, ie_q});
				mul_en = 1'b1;
			end
			ST_M_WW: begin
				mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	wrmll_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_comb begin
		state_d = state_q;
		ovf_set = 1'b0;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DIFF;
			ST_DIFF:  begin
				state_d = ST_M_D2;
				ovf_set = diff_ovf;
			end
			ST_M_D2:  state_d = ST_T_D2;
			ST_T_D2:  begin
				state_d = ST_M_SQ;
				ovf_set = tr_ovf;
			end
			ST_M_SQ:  state_d = ST_T_SQ;
			ST_T_SQ:  begin
				state_d = kind_q ? ST_M_D3 : ST_RESID;
				ovf_set = tr_ovf;
			end
			ST_M_D3:  state_d = ST_T_D3;
			ST_T_D3:  begin
				state_d = ST_M_CU;
				ovf_set = tr_ovf;
			end
			ST_M_CU:  state_d = ST_T_CU;
			ST_T_CU:  begin
				state_d = ST_RESID;
				ovf_set = tr_ovf;
			end
			ST_RESID: begin
				state_d = ST_M_W;
				ovf_set = mod_ovf | res_ovf;
			end
			ST_M_W:   state_d = ST_T_W;
			ST_T_W:   begin
				state_d = ST_M_WW;
				ovf_set = tr_ovf;
			end
			ST_M_WW:  state_d = ST_ACC;
			ST_ACC:   if (!last_q || room) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t_q    <= position;
			val_q  <= measured_value;
			ie_q   <= inverse_error;
			last_q <= last_point;
		end
		unique case (state_q)
			ST_DIFF:  x_q   <= diff_val;
			ST_T_D2:  y_q   <= tr_val;
			ST_T_SQ:  acc_q <= {{2{base_q[DATA_W-1]}}, base_q} + {{2{tr_val[DATA_W-1]}}, tr_val};
			ST_T_D3:  y_q   <= tr_val;
			ST_T_CU:  acc_q <= acc_q + {{2{tr_val[DATA_W-1]}}, tr_val};
			ST_RESID: x_q   <= res_val;
			ST_T_W:   x_q   <= tr_val;
			default: ;
		endcase
	end

	// The square of the weighted residual is non-negative and below 2^63.
	assign term = {1'b0, mul_p[SUM_W-1:1]};

	assign acc_ctrl.step    = (state_q == ST_ACC) && (!last_q || room);
	assign acc_ctrl.last    = last_q;
	assign acc_ctrl.ovf_set = ovf_set;

	wrmll_acc u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (acc_ctrl),
		.term           (term),
		.room           (room),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.log_likelihood (log_likelihood),
		.saturated      (saturated)
	);

	a_sum_nonpositive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (log_likelihood[SUM_W-1] || log_likelihood == '0))
		else $error("log-likelihood beat is positive");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready again straight after an accepted beat");

	a_out_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_ACC && last_q))
		else $error("output beat raised outside the accumulate step of a last point");

endmodule
`default_nettype wire

[bench/weighted_residual_loglik_tb.sv]
// Self-checking testbench for the weighted residual log-likelihood block.
`default_nettype none
module weighted_residual_loglik_tb;
	import wrmll_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC_BITS = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam longint SUM_FLOOR = {1'b1, 63'd0};
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned POINTS_PER_PHASE = 190;

	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic             flagged;
	} loglik_total_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [DATA_W-1:0]    position;
	logic [DATA_W-1:0]    measured_value;
	logic [DATA_W-1:0]    inverse_error;
	logic                 last_point;
	logic                 out_valid;
	logic                 out_ready;
	logic [SUM_W-1:0]     log_likelihood;
	logic                 saturated;

	logic          cubic_sel;
	longint        base_lvl;
	longint        centre_pos;
	longint        square_gain;
	longint        cube_gain;
	logic [31:0]   centre_word;
	longint        sum_total;
	logic          sum_flagged;
	loglik_total_t expected_totals[$];

	logic        idle_enabled;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned totals_checked;
	int unsigned flagged_totals;
	int unsigned points_sent;
	int unsigned settings_used;

	weighted_residual_loglik #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.position       (position),
		.measured_value (measured_value),
		.inverse_error  (inverse_error),
		.last_point     (last_point),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.log_likelihood (log_likelihood),
		.saturated      (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint widen_signed(input logic [31:0] w);
		return {{32{w[31]}}, w};
	endfunction

	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX) begin
			sum_flagged = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			sum_flagged = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	function automatic longint fixed_mul(input longint a, input longint b);
		longint prod;
		prod = a * b;
		return clamp_word(prod >>> FRAC_BITS);
	endfunction

	function automatic void fold_point(input logic [31:0] pos, input logic [31:0] meas,
			input logic [31:0] inv, input logic last);
		longint offset;
		longint offset_sq;
		longint model_acc;
		longint model;
		longint resid;
		longint scaled;
		longint term;
		offset = clamp_word(widen_signed(pos) - centre_pos);
		offset_sq = fixed_mul(offset, offset);
		model_acc = base_lvl + fixed_mul(offset_sq, square_gain);
		if (cubic_sel)
			model_acc += fixed_mul(fixed_mul(offset_sq, offset), cube_gain);
		model = clamp_word(model_acc);
		resid = clamp_word(widen_signed(meas) - model);
		scaled = fixed_mul(resid, {32'd0, inv});
		term = (scaled * scaled) >>> 1;
		if (sum_total < SUM_FLOOR + term) begin
			sum_total = SUM_FLOOR;
			sum_flagged = 1'b1;
		end else begin
			sum_total -= term;
		end
		if (last) begin
			expected_totals.push_back('{total: sum_total, flagged: sum_flagged});
			if (sum_flagged)
				flagged_totals++;
			sum_total = 0;
			sum_flagged = 1'b0;
		end
	endfunction

	function automatic logic [31:0] pick_field(input int unsigned span);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				v = $urandom_range(0, 2 * span);
				v = v - span;
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < 40)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_MODEL_KIND: cubic_sel = data[0];
			REG_BASE_VALUE: base_lvl = widen_signed(data);
			REG_CENTER_POSITION: begin
				centre_pos = widen_signed(data);
				centre_word = data;
			end
			REG_SQUARE_COEF: square_gain = widen_signed(data);
			REG_CUBE_COEF: cube_gain = widen_signed(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_registers(input logic [31:0] kind, input logic [31:0] base,
			input logic [31:0] centre, input logic [31:0] square, input logic [31:0] cube);
		write_register(REG_MODEL_KIND, kind);
		write_register(REG_BASE_VALUE, base);
		write_register(REG_CENTER_POSITION, centre);
		write_register(REG_SQUARE_COEF, square);
		write_register(REG_CUBE_COEF, cube);
		settings_used++;
	endtask

	// Called straight after the previous beat was taken, so valid may stay high.
	task automatic send_point(input logic [31:0] pos, input logic [31:0] meas,
			input logic [31:0] inv, input logic last);
		int unsigned gap;
		gap = idle_enabled ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		position <= pos;
		measured_value <= meas;
		inverse_error <= inv;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
		fold_point(pos, meas, inv, last);
		points_sent++;
	endtask

	task automatic park_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic settle_block();
		park_input();
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_registers();
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
		settle_block();
	endtask

	task automatic test_product_truncation();
		load_registers(32'd0, 32'h0000_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'd0);
		send_point(32'h0001_0003, 32'h0000_0001, 32'h0000_8001, 1'b1);
		send_point(32'hFFFF_7FFF, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
		send_point(32'h0002_3456, 32'hFFFE_1234, 32'h0001_ABCD, 1'b1);
		settle_block();
	endtask

	task automatic test_intermediate_overflow();
		load_registers(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
		send_point(32'h8000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1);
		settle_block();
	endtask

	// Four full-scale terms stop just short of the floor; a fifth crosses it.
	task automatic test_sum_underflow();
		load_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		for (int k = 0; k < 4; k++)
			send_point(32'd0, 32'h7FFF_FFFF, 32'h0001_0000, k == 3);
		for (int k = 0; k < 5; k++)
			send_point(32'd0, 32'h7FFF_FFFF, 32'h0001_0000, k == 4);
		settle_block();
	endtask

	task automatic test_unused_register_bits();
		load_registers(32'hFFFF_FFFE, 32'h0001_0000, 32'h0000_0000, 32'h0000_4000,
			32'h0003_0000);
		write_register(REG_SPARE, 32'hFFFF_FFFF);
		send_point(32'h0002_0000, 32'h0000_8000, 32'h0000_C000, 1'b1);
		settle_block();
		write_register(REG_MODEL_KIND, 32'h8000_0003);
		send_point(32'hFFFE_0000, 32'h0000_8000, 32'h0000_C000, 1'b1);
		settle_block();
	endtask

	task automatic test_cubic_model();
		load_registers(32'd1, 32'hFFFE_8000, 32'h0001_4000, 32'hFFFF_2000, 32'h0000_6001);
		send_point(32'h0003_1234, 32'h0002_0000, 32'h0001_0000, 1'b0);
		send_point(32'hFFFD_0001, 32'hFFF0_0000, 32'h0000_0101, 1'b0);
		send_point(32'h0001_4000, 32'h0000_0000, 32'h0004_0000, 1'b1);
		settle_block();
	endtask

	task automatic test_random_data_sets();
		int unsigned phase_points;
		int unsigned set_len;
		logic [31:0] inv;
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			idle_enabled = (phase % 3) != 2;
			case (phase)
				0: load_registers(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF);
				1: load_registers(32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 32'h8000_0000);
				default: load_registers($urandom(), pick_field(32'h10_0000),
					pick_field(32'h10_0000), pick_field(32'h2_0000), pick_field(32'h8000));
			endcase
			phase_points = 0;
			while (phase_points < POINTS_PER_PHASE) begin
				set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int unsigned k = 0; k < set_len; k++) begin
					inv = ($urandom_range(0, 4) == 0) ? pick_field(32'h4_0000)
						: 32'($urandom_range(0, 32'h4_0000));
					send_point(centre_word + pick_field(32'h8_0000), pick_field(32'h40_0000),
						inv, k == set_len - 1);
				end
				phase_points += set_len;
				if (phase == 3 && phase_points >= POINTS_PER_PHASE / 2
						&& phase_points - set_len < POINTS_PER_PHASE / 2)
					settle_block();
			end
			settle_block();
		end
	endtask

	initial begin : result_drain
		int unsigned hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_enabled ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			if (hold != 0) begin
				out_ready <= 1'b0;
				while (!out_valid) @(negedge clk);
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		loglik_total_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_totals.size() == 0) begin
				report_mismatch("unexpected result beat", log_likelihood, 64'd0);
			end else begin
				want = expected_totals.pop_front();
				if (log_likelihood !== want.total)
					report_mismatch("log_likelihood", log_likelihood, want.total);
				if (saturated !== want.flagged)
					report_mismatch("saturated", {63'd0, saturated}, {63'd0, want.flagged});
				totals_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d totals outstanding.", cycle_count,
				expected_totals.size());
			$display("weighted_residual_loglik regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODEL_KIND;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		position = 32'd0;
		measured_value = 32'd0;
		inverse_error = 32'd0;
		last_point = 1'b0;
		cubic_sel = 1'b0;
		base_lvl = 0;
		centre_pos = 0;
		square_gain = 0;
		cube_gain = 0;
		centre_word = 32'd0;
		sum_total = 0;
		sum_flagged = 1'b0;
		idle_enabled = 1'b1;
		error_count = 0;
		cycle_count = 0;
		totals_checked = 0;
		flagged_totals = 0;
		points_sent = 0;
		settings_used = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_product_truncation();
		test_intermediate_overflow();
		test_sum_underflow();
		test_unused_register_bits();
		test_cubic_model();
		test_random_data_sets();

		settle_block();
		if (expected_totals.size() != 0)
			report_mismatch("totals never delivered", 64'(expected_totals.size()), 64'd0);
		$display("Sent %0d points under %0d register settings and checked %0d data-set totals.",
			points_sent, settings_used, totals_checked);
		$display("%0d of those totals carried the saturation flag; %0d mismatches.",
			flagged_totals, error_count);
		if (error_count == 0)
			$display("weighted_residual_loglik regression: pass");
		else
			$display("weighted_residual_loglik regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
